// ----- sv/lkx_pkg.sv -----
// Shared types, constants and helper functions of the LCG key XOR cipher.
`timescale 1ns / 1ps

package lkx_pkg;

    localparam int KEY_LENGTH = 32;
    localparam int KEY_POS_W  = (KEY_LENGTH > 1) ? $clog2(KEY_LENGTH) : 1;
    localparam int DRAW_W     = 15;
    localparam int DATA_W     = 8;
    localparam int STATE_W    = 32;
    localparam int CFG_AW     = 3;
    localparam int CFG_DW     = 32;

    localparam logic [STATE_W-1:0] LCG_MUL = 32'd214013;
    localparam logic [STATE_W-1:0] LCG_INC = 32'd2531011;

    // Word index of the seed register on the configuration port.
    localparam logic [CFG_AW-3:0] REG_SEED = '0;

    localparam logic [KEY_POS_W-1:0] KEY_POS_LAST = KEY_POS_W'(KEY_LENGTH - 1);

    typedef logic [KEY_POS_W-1:0] t_key_pos;

    // Work carried from the generator stage to the key stage.
    typedef struct packed {
        logic [DATA_W-1:0] data_byte;
        logic [DRAW_W-1:0] draw;
        logic              gen;
        t_key_pos          pos;
    } t_gen_item;

    // Remainder modulo 61 of a 15-bit draw, folded with 256 = 12 and 64 = 3 (mod 61).
    function automatic logic [5:0] mod61(input logic [DRAW_W-1:0] x);
        logic [10:0] y;
        logic [7:0]  z;
        logic [7:0]  r;
        y = ({4'd0, x[14:8]} << 3) + ({4'd0, x[14:8]} << 2) + {3'd0, x[7:0]};
        z = {3'd0, y[10:6]} + {2'd0, y[10:6], 1'b0} + {2'd0, y[5:0]};
        if (z >= 8'd122) begin
            r = z - 8'd122;
        end else if (z >= 8'd61) begin
            r = z - 8'd61;
        end else begin
            r = z;
        end
        return r[5:0];
    endfunction

    // Maps 0..60 onto a-z, A-Z, 1-9.
    function automatic logic [DATA_W-1:0] key_char(input logic [5:0] v);
        logic [DATA_W-1:0] w;
        w = {2'd0, v};
        if (v < 6'd26) begin
            return 8'h61 + w;
        end else if (v < 6'd52) begin
            return 8'h41 + w - 8'd26;
        end else begin
            return 8'h31 + w - 8'd52;
        end
    endfunction

endpackage

// ----- sv/lkx_in_if.sv -----
// Input and output stream interfaces of the LCG key XOR cipher.
`timescale 1ns / 1ps

interface lkx_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       restart;

    modport source (output valid, output data_byte, output restart, input ready);
    modport sink   (input valid, input data_byte, input restart, output ready);
endinterface

interface lkx_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;

    modport source (output valid, output out_byte, input ready);
    modport sink   (input valid, input out_byte, output ready);
endinterface

// ----- sv/lkx_cfg_regs.sv -----
// APB-style configuration port holding the seed register.
`timescale 1ns / 1ps

module lkx_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lkx_pkg::CFG_AW-1:0]    paddr,
    input  logic [lkx_pkg::CFG_DW-1:0]    pwdata,
    output logic [lkx_pkg::CFG_DW-1:0]    prdata,
    output logic                          pready,
    output logic [lkx_pkg::STATE_W-1:0]   o_seed
);

    logic [lkx_pkg::STATE_W-1:0] r_seed;
    logic                        sel_seed;

    assign pready   = 1'b1;
    assign sel_seed = (paddr[lkx_pkg::CFG_AW-1:2] == lkx_pkg::REG_SEED);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
        end else if (psel && penable && pwrite && sel_seed) begin
            r_seed <= pwdata;
        end
    end

    always_comb begin
        prdata = '0;
        if (sel_seed) begin
            prdata = r_seed;
        end
    end

    assign o_seed = r_seed;

endmodule

// ----- sv/lkx_gen_stage.sv -----
// First stage: message control, key position and generator update.
`timescale 1ns / 1ps

module lkx_gen_stage (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [lkx_pkg::STATE_W-1:0]   i_seed,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [lkx_pkg::DATA_W-1:0]    i_data_byte,
    input  logic                          i_restart,
    input  logic                          i_take,
    output logic                          o_valid,
    output lkx_pkg::t_gen_item            o_item
);

    logic [lkx_pkg::STATE_W-1:0] r_lcg_state;
    logic [lkx_pkg::STATE_W-1:0] n_lcg_state;
    lkx_pkg::t_key_pos           r_key_pos;
    lkx_pkg::t_key_pos           n_key_pos;
    logic                        r_key_complete;
    logic                        n_key_complete;
    logic                        r_need_reseed;
    logic                        r_valid;
    lkx_pkg::t_gen_item          r_item;
    lkx_pkg::t_gen_item          n_item;

    logic                        accept;
    logic                        reseed;
    logic [lkx_pkg::STATE_W-1:0] base_state;
    lkx_pkg::t_key_pos           cur_pos;
    logic                        cur_complete;
    logic [lkx_pkg::STATE_W-1:0] stepped;

    assign o_ready = !r_valid || i_take;
    assign accept  = i_valid && o_ready;
    assign reseed  = i_restart || r_need_reseed;

    always_comb begin
        base_state   = reseed ? i_seed : r_lcg_state;
        cur_pos      = reseed ? '0 : r_key_pos;
        cur_complete = reseed ? 1'b0 : r_key_complete;
        stepped      = base_state * lkx_pkg::LCG_MUL + lkx_pkg::LCG_INC;

        n_lcg_state    = cur_complete ? base_state : stepped;
        n_key_complete = cur_complete;
        if (cur_pos == lkx_pkg::KEY_POS_LAST) begin
            n_key_pos      = '0;
            n_key_complete = 1'b1;
        end else begin
            n_key_pos = cur_pos + 1'b1;
        end

        n_item.data_byte = i_data_byte;
        n_item.draw      = stepped[30:16];
        n_item.gen       = !cur_complete;
        n_item.pos       = cur_pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lcg_state    <= '0;
            r_key_pos      <= '0;
            r_key_complete <= 1'b0;
            r_need_reseed  <= 1'b1;
            r_valid        <= 1'b0;
        end else begin
            if (accept) begin
                r_lcg_state    <= n_lcg_state;
                r_key_pos      <= n_key_pos;
                r_key_complete <= n_key_complete;
                r_need_reseed  <= 1'b0;
            end
            if (o_ready) begin
                r_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ----- sv/lkx_key_stage.sv -----
// Second stage: key character mapping, key store and output register.
`timescale 1ns / 1ps

module lkx_key_stage (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  lkx_pkg::t_gen_item            i_item,
    output logic                          o_take,
    output logic                          o_valid,
    output logic [lkx_pkg::DATA_W-1:0]    o_out_byte,
    input  logic                          i_ready
);

    logic [lkx_pkg::DATA_W-1:0] r_key_store [lkx_pkg::KEY_LENGTH];
    logic                       r_out_valid;
    logic [lkx_pkg::DATA_W-1:0] r_out_byte;
    logic [lkx_pkg::DATA_W-1:0] new_char;
    logic [lkx_pkg::DATA_W-1:0] key_byte;
    logic                       move;

    assign o_take = !r_out_valid || i_ready;
    assign move   = i_valid && o_take;

    // Stored entries are read only once the whole key of this message has
    // been written, and every write has left this stage by then.
    always_comb begin
        new_char = lkx_pkg::key_char(lkx_pkg::mod61(i_item.draw));
        key_byte = i_item.gen ? new_char : r_key_store[i_item.pos];
    end

    always_ff @(posedge i_clk) begin
        if (move && i_item.gen) begin
            r_key_store[i_item.pos] <= new_char;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_take) begin
            r_out_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_out_byte <= i_item.data_byte ^ key_byte;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_out_byte = r_out_byte;

endmodule

// ----- sv/lcg_key_xor_cipher_unit.sv -----
// Each item's byte is XORed with a key character: bits 30..16 of an LCG
// (x * 214013 + 2531011 mod 2^32) taken mod 61 and mapped to a-z, A-Z, 1-9
// over the first 32 bytes of a message, then the stored 32-byte key repeats.
// The first item after reset, or any item with restart set, reloads the
// generator from the seed register (byte address 0) and starts the key over.
// One item is accepted every cycle unless the output stalls; each result
// passes the generator register stage and then the output register. The
// generator multiply-add is combinational and sets the item rate. The seed
// must be written only while the block is idle; the block itself does not
// enforce this. A new seed takes effect at the next message start.
`timescale 1ns / 1ps

module lcg_key_xor_cipher_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lkx_pkg::CFG_AW-1:0]    paddr,
    input  logic [lkx_pkg::CFG_DW-1:0]    pwdata,
    output logic [lkx_pkg::CFG_DW-1:0]    prdata,
    output logic                          pready,
    lkx_in_if.sink                        i_in,
    lkx_out_if.source                     o_out
);

    logic [lkx_pkg::STATE_W-1:0] seed;
    logic                        gen_valid;
    lkx_pkg::t_gen_item          gen_item;
    logic                        key_take;

    lkx_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_seed  (seed)
    );

    lkx_gen_stage u_gen (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_seed      (seed),
        .i_valid     (i_in.valid),
        .o_ready     (i_in.ready),
        .i_data_byte (i_in.data_byte),
        .i_restart   (i_in.restart),
        .i_take      (key_take),
        .o_valid     (gen_valid),
        .o_item      (gen_item)
    );

    lkx_key_stage u_key (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (gen_valid),
        .i_item     (gen_item),
        .o_take     (key_take),
        .o_valid    (o_out.valid),
        .o_out_byte (o_out.out_byte),
        .i_ready    (o_out.ready)
    );

endmodule
